// ===== hdl/sld_pkg.sv =====
// Spin-loop detector package: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
package sld_pkg;
  localparam logic [1:0] KIND_DISPATCH = 2'd0;
  localparam logic [1:0] KIND_SCAN_REQ = 2'd1;
  localparam logic [1:0] KIND_SCAN_DONE = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_TIMING = 2'd1;
  localparam logic [1:0] CLASS_AUDIO = 2'd2;
  localparam logic [1:0] CLASS_OTHER = 2'd3;

  localparam logic [7:0] BYTE_TIMING_OP = 8'h42;
  localparam logic [7:0] BYTE_TIMING_LO = 8'h10;
  localparam logic [7:0] BYTE_TIMING_HI = 8'h12;
  localparam logic [7:0] BYTE_AUDIO_OP = 8'h21;
  localparam logic [7:0] BYTE_AUDIO_LO = 8'h40;
  localparam logic [7:0] BYTE_AUDIO_HI = 8'h43;
  localparam logic [15:0] REG_PC_LO = 16'h2000;
  localparam logic [15:0] REG_PC_HI = 16'h8000;
  localparam logic [7:0] BANK_LOW_END = 8'h40;
  localparam logic [7:0] BANK_MIRROR_LO = 8'h80;
  localparam logic [7:0] BANK_MIRROR_HI = 8'hc0;
  localparam logic [16:0] WINDOW_SPAN = 17'd40;
  localparam logic [3:0] HITS_MAX = 4'd15;
  localparam logic [3:0] CONFIRM_RESET = 4'd3;
  localparam logic [1:0] REG_CONFIRM_HITS = 2'd0;

  typedef struct packed {
    logic        command;
    logic [23:0] address;
    logic [7:0]  dots;
    logic        counting_on;
    logic [7:0]  code_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  loop_class;
    logic [23:0] scan_start;
    logic [5:0]  scan_length;
    logic [63:0] timing_poll_dots;
    logic [63:0] audio_poll_dots;
    logic [63:0] other_loop_dots;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic hist;      // history compare + push + period update
    logic credit;    // add dots for a confirmed loop of known class
    logic scan_step; // one history entry into min/max
    logic decide;    // class decision after cache read
    logic byte_in;   // code byte handling
    logic reject;
    logic emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_byte;
    logic confirmed;  // confirmed and class unknown -> needs lookup
    logic scan_last;
    logic scan_busy;
  } dp_sts_t;
endpackage

// ===== hdl/sld_if.sv =====
// Valid/ready channel interface carrying one beat of payload.
// No dependencies; the payload type is set by the parameter type.
`timescale 1ns / 1ps
interface sld_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/sld_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module sld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/sld_datapath.sv =====
// Datapath: history, period tracking, window min/max, cache, byte classifier, totals.
// Depends on sld_pkg and sld_ram.
`timescale 1ns / 1ps
module sld_datapath import sld_pkg::*; #(
  parameter int HISTORY_DEPTH = 12,
  parameter int CACHE_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic [3:0] confirm_hits,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_item_t out_data
);
  localparam int HW = $clog2(HISTORY_DEPTH + 1);
  localparam int HI = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(CACHE_ENTRIES);

  in_item_t    item;
  logic [23:0] hist [HISTORY_DEPTH];
  logic [HW-1:0] history_count;
  logic [HW-1:0] loop_period;
  logic [3:0]  repeat_hits;
  logic [1:0]  current_class;
  logic [CACHE_ENTRIES-1:0] cache_valid;
  logic [63:0] timing_total, audio_total, other_total;
  logic        scan_busy;
  logic [23:0] scan_key;
  logic [5:0]  bytes_expected, bytes_seen;
  logic [7:0]  previous_byte;
  logic        saw_timing, saw_audio;
  logic [7:0]  held_dots;
  logic        held_counting;
  logic [HW-1:0] idx;
  logic        one_bank;
  logic [15:0] lo, hi;
  logic [23:0] key;

  logic [HW-1:0] match;
  always_comb begin
    match = '0;
    for (int i = HISTORY_DEPTH - 1; i >= 0; i--) begin
      if (HW'(i) < history_count && hist[i] == item.address) match = HW'(i + 1);
    end
  end

  logic [3:0] ch_eff;
  assign ch_eff = (confirm_hits == 4'd0) ? 4'd1 : confirm_hits;
  logic confirmed;
  assign confirmed = (loop_period != '0) && (repeat_hits >= ch_eff);

  // cache rams
  logic        c_we;
  logic [1:0]  c_wclass;
  logic [23:0] c_wtag;
  logic [CW-1:0] c_waddr;
  logic [23:0] rd_tag;
  logic [1:0]  rd_class;
  assign key = {item.address[23:16], lo};
  sld_ram #(.WIDTH(24), .DEPTH(CACHE_ENTRIES)) u_tag (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wtag),
    .raddr(key[CW-1:0]), .rdata(rd_tag));
  sld_ram #(.WIDTH(2), .DEPTH(CACHE_ENTRIES)) u_cls (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wclass),
    .raddr(key[CW-1:0]), .rdata(rd_class));

  logic [15:0] hpc;
  assign hpc = hist[idx[HI-1:0]][15:0];
  logic [15:0] top;
  logic [16:0] span;
  assign span = {1'b0, hi} + 17'd4 - {1'b0, lo};
  assign top = (span > WINDOW_SPAN) ? 16'(lo + 16'd40) : 16'(hi + 16'd4);
  logic [5:0] scan_len;
  assign scan_len = 6'(top - lo + 16'd1);
  logic guard_bank;
  assign guard_bank = item.address[23:16] < BANK_LOW_END ||
    (item.address[23:16] >= BANK_MIRROR_LO && item.address[23:16] < BANK_MIRROR_HI);
  logic [1:0] byte_cls;
  logic bt, ba;
  assign bt = (bytes_seen != 0) && item.code_byte == BYTE_TIMING_OP &&
    previous_byte >= BYTE_TIMING_LO && previous_byte <= BYTE_TIMING_HI;
  assign ba = (bytes_seen != 0) && item.code_byte == BYTE_AUDIO_OP &&
    previous_byte >= BYTE_AUDIO_LO && previous_byte <= BYTE_AUDIO_HI;
  assign byte_cls = (saw_timing || bt) ? CLASS_TIMING :
    ((saw_audio || ba) ? CLASS_AUDIO : CLASS_OTHER);

  assign sts.is_byte = item.command;
  assign sts.confirmed = confirmed && current_class == CLASS_NONE;
  assign sts.scan_last = (idx + 1'b1 >= loop_period) || !one_bank;
  assign sts.scan_busy = scan_busy;

  always_comb begin
    c_we = 1'b0; c_wclass = CLASS_OTHER; c_wtag = key; c_waddr = key[CW-1:0];
    if (cmd.decide && one_bank &&
        !(cache_valid[key[CW-1:0]] && rd_tag == key) &&
        guard_bank && lo >= REG_PC_LO && lo < REG_PC_HI) c_we = 1'b1;
    if (cmd.byte_in && 6'(bytes_seen + 1'b1) >= bytes_expected) begin
      c_we = 1'b1; c_wclass = byte_cls; c_wtag = scan_key; c_waddr = scan_key[CW-1:0];
    end
  end

  logic [1:0] emit_kind, emit_class;
  logic       emit_req;
  always_comb begin
    emit_kind = KIND_DISPATCH; emit_class = CLASS_NONE; emit_req = 1'b0;
    if (cmd.reject) emit_kind = KIND_REJECT;
    else if (!item.command && confirmed) begin
      if (scan_busy) begin
        emit_kind = KIND_SCAN_REQ; emit_req = 1'b1;
      end else emit_class = current_class;
    end else if (item.command && !scan_busy) begin
      emit_kind = KIND_SCAN_DONE; emit_class = current_class;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
    if (cmd.hist) begin
      for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist[i] <= hist[i-1];
      hist[0] <= item.address;
      idx <= '0; one_bank <= 1'b1; lo <= 16'hffff; hi <= '0;
    end
    if (cmd.scan_step) begin
      idx <= idx + 1'b1;
      if (hist[idx[HI-1:0]][23:16] != item.address[23:16]) one_bank <= 1'b0;
      else begin
        if (hpc < lo) lo <= hpc;
        if (hpc > hi) hi <= hpc;
      end
    end
    if (cmd.emit) begin
      out_data.kind <= emit_kind;
      out_data.loop_class <= emit_class;
      out_data.scan_start <= emit_req ? scan_key : 24'd0;
      out_data.scan_length <= emit_req ? bytes_expected : 6'd0;
      out_data.timing_poll_dots <= timing_total;
      out_data.audio_poll_dots <= audio_total;
      out_data.other_loop_dots <= other_total;
    end
    if (rst) begin
      history_count <= '0; loop_period <= '0; repeat_hits <= '0;
      current_class <= CLASS_NONE; cache_valid <= '0;
      timing_total <= '0; audio_total <= '0; other_total <= '0;
      scan_busy <= 1'b0; scan_key <= '0; bytes_expected <= '0; bytes_seen <= '0;
      previous_byte <= '0; saw_timing <= 1'b0; saw_audio <= 1'b0;
      held_dots <= '0; held_counting <= 1'b0;
    end else begin
      if (c_we) cache_valid[c_waddr] <= 1'b1;
      if (cmd.hist) begin
        if (history_count < HW'(HISTORY_DEPTH)) history_count <= history_count + 1'b1;
        if (match != '0 && match == loop_period) begin
          if (repeat_hits < HITS_MAX) repeat_hits <= repeat_hits + 1'b1;
        end else if (match != '0) begin
          loop_period <= match; repeat_hits <= 4'd1; current_class <= CLASS_NONE;
        end else begin
          loop_period <= '0; repeat_hits <= '0; current_class <= CLASS_NONE;
        end
      end
      if (cmd.decide) begin
        if (!one_bank) begin
          current_class <= CLASS_OTHER;
          if (item.counting_on) other_total <= other_total + 64'(item.dots);
        end else if (cache_valid[key[CW-1:0]] && rd_tag == key) begin
          current_class <= rd_class;
          if (item.counting_on) begin
            case (rd_class)
              CLASS_TIMING: timing_total <= timing_total + 64'(item.dots);
              CLASS_AUDIO: audio_total <= audio_total + 64'(item.dots);
              default: other_total <= other_total + 64'(item.dots);
            endcase
          end
        end else if (c_we) begin
          current_class <= CLASS_OTHER;
          if (item.counting_on) other_total <= other_total + 64'(item.dots);
        end else begin
          scan_busy <= 1'b1; scan_key <= key; bytes_expected <= scan_len;
          bytes_seen <= '0; previous_byte <= '0; saw_timing <= 1'b0; saw_audio <= 1'b0;
          held_dots <= item.dots; held_counting <= item.counting_on;
        end
      end
      // known class on a confirmed dispatch (no lookup)
      if (cmd.credit && confirmed && current_class != CLASS_NONE && item.counting_on) begin
        case (current_class)
          CLASS_TIMING: timing_total <= timing_total + 64'(item.dots);
          CLASS_AUDIO: audio_total <= audio_total + 64'(item.dots);
          default: other_total <= other_total + 64'(item.dots);
        endcase
      end
      if (cmd.byte_in) begin
        previous_byte <= item.code_byte;
        bytes_seen <= bytes_seen + 1'b1;
        if (bt) saw_timing <= 1'b1;
        if (ba) saw_audio <= 1'b1;
        if (6'(bytes_seen + 1'b1) >= bytes_expected) begin
          current_class <= byte_cls; scan_busy <= 1'b0;
          if (held_counting) begin
            case (byte_cls)
              CLASS_TIMING: timing_total <= timing_total + 64'(held_dots);
              CLASS_AUDIO: audio_total <= audio_total + 64'(held_dots);
              default: other_total <= other_total + 64'(held_dots);
            endcase
          end
        end
      end
    end
  end
endmodule

// ===== hdl/sld_ctrl.sv =====
// Controller state machine: sequences capture, history update, window scan,
// cache lookup and result beat. Depends on sld_pkg.
`timescale 1ns / 1ps
module sld_ctrl import sld_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_LOOK = 3'd4;
  localparam logic [2:0] S_DEC = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state, state_next;
  logic out_full;
  logic mode; // 1 = reject

  assign in_ready = (state == S_IDLE) && (!out_full || out_ready);
  assign out_valid = out_full;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1; state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_byte != sts.scan_busy) state_next = S_EMIT;
        else if (sts.is_byte) begin
          cmd.byte_in = 1'b1; state_next = S_EMIT;
        end else begin
          cmd.hist = 1'b1; state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.confirmed) state_next = S_SCAN;
        else begin
          cmd.credit = 1'b1; state_next = S_EMIT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_LOOK;
      end
      S_LOOK: state_next = S_DEC;
      S_DEC: begin
        cmd.decide = 1'b1; state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_full || out_ready) begin
          cmd.emit = 1'b1; cmd.reject = mode; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_full <= 1'b0; mode <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) mode <= sts.is_byte != sts.scan_busy;
      if (cmd.emit) out_full <= 1'b1;
      else if (out_ready) out_full <= 1'b0;
    end
  end
endmodule

// ===== hdl/spin_loop_detector_classifier.sv =====
// channel | dir | protocol  | payload
// in      | in  | valid/rdy | command, address, dots, counting_on, code_byte
// out     | out | valid/rdy | kind, loop_class, scan_start, scan_length, totals
// cfg     | in  | APB       | confirm_hits at 0x0
// A code byte or rejected beat runs capture, execute, emit; a dispatch adds a check,
// and a confirmed loop of unknown class adds a history window scan, cache read and decide.
// One item in flight; a held output register lets the next beat in as it drains.
// Synchronous reset clears control, totals and cache valid bits.
`timescale 1ns / 1ps
module spin_loop_detector_classifier import sld_pkg::*; #(
  parameter int HISTORY_DEPTH = 12,
  parameter int CACHE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  sld_if.sink         in_ch,
  sld_if.source       out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [3:0] confirm_hits;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == {REG_CONFIRM_HITS}) ? {28'd0, confirm_hits} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) confirm_hits <= CONFIRM_RESET;
    else if (psel && penable && pwrite && paddr == REG_CONFIRM_HITS)
      confirm_hits <= pwdata[3:0];
  end

  sld_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd));

  sld_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH), .CACHE_ENTRIES(CACHE_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .confirm_hits(confirm_hits), .in_data(in_ch.data),
    .cmd(cmd), .sts(sts), .out_data(out_ch.data));
endmodule

// ===== hdl/sld_checker.sv =====
// Port-level checker for the spin-loop detector, bound to the top level.
// Depends on sld_pkg.
`timescale 1ns / 1ps
module sld_props import sld_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_item_t out_data
);
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_SCAN_REQ |-> out_data.scan_length == 6'd0)
    else $error("scan_length nonzero outside scan request");
  a_reqlen: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_SCAN_REQ |->
      out_data.scan_length >= 6'd5 && out_data.scan_length <= 6'd41)
    else $error("scan length out of range");
  a_rejcls: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_REJECT |-> out_data.loop_class == CLASS_NONE)
    else $error("reject with class");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat dropped");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("two beats accepted back to back");
endmodule

bind spin_loop_detector_classifier sld_props u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
